// ===== sv/fqd_pkg.sv =====
// Shared types, codes and hex helpers for the form query decoder.
`timescale 1ns / 1ps
`default_nettype none
package fqd_pkg;

  localparam int unsigned MaxRes = 4;

  localparam logic [7:0] ChPct   = 8'h25;  // '%'
  localparam logic [7:0] ChPlus  = 8'h2B;  // '+'
  localparam logic [7:0] ChEq    = 8'h3D;  // '='
  localparam logic [7:0] ChAmp   = 8'h26;  // '&'
  localparam logic [7:0] ChSpace = 8'h20;  // ' '
  localparam logic [7:0] HexBase = 8'h10;

  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_MARK  = 2'd2
  } kind_e;

  // escape progress, one-hot
  typedef enum logic [2:0] {
    ESC_NONE  = 3'b001,
    ESC_PCT   = 3'b010,
    ESC_DIGIT = 3'b100
  } esc_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] dat;
    logic       keep;
  } res_t;

  // all results caused by one input transaction
  typedef struct packed {
    res_t [MaxRes-1:0] res;
    logic [2:0]        cnt;
  } batch_t;

  function automatic logic is_hex(input logic [7:0] b);
    is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
             (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) v = b - 8'h30;
    else if (b >= 8'h61 && b <= 8'h66) v = b - 8'h57;
    else if (b >= 8'h41 && b <= 8'h46) v = b - 8'h37;
    hex_val = v[3:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/fqd_core.sv =====
// Decode state and per-byte result list generation.
`timescale 1ns / 1ps
`default_nettype none
module fqd_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            acc_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            final_i,
  output fqd_pkg::batch_t      batch_o
);

  logic             ivp_q, ivp_d;
  logic             vs_q, vs_d;
  fqd_pkg::esc_e    esc_q, esc_d;
  logic [7:0]       hd_q, hd_d;

  always_comb begin
    fqd_pkg::batch_t b;
    fqd_pkg::kind_e  ck;
    logic            hex;
    logic            do_plain;
    logic            ended;
    b        = '0;
    ck       = ivp_q ? fqd_pkg::KIND_VALUE : fqd_pkg::KIND_NAME;
    hex      = fqd_pkg::is_hex(byte_i);
    do_plain = 1'b0;
    ended    = 1'b0;
    ivp_d    = ivp_q;
    vs_d     = vs_q;
    esc_d    = esc_q;
    hd_d     = hd_q;

    unique case (esc_q)
      fqd_pkg::ESC_PCT: begin
        if (hex) begin
          hd_d  = byte_i;
          esc_d = fqd_pkg::ESC_DIGIT;
        end else begin
          b.res[b.cnt[1:0]] = '{ck, fqd_pkg::ChPct, 1'b0};
          b.cnt = b.cnt + 3'd1;
          esc_d = fqd_pkg::ESC_NONE;
          do_plain = 1'b1;
        end
      end
      fqd_pkg::ESC_DIGIT: begin
        if (hex) begin
          b.res[b.cnt[1:0]] = '{ck, {fqd_pkg::hex_val(hd_q), fqd_pkg::hex_val(byte_i)},
                                1'b0};
          b.cnt = b.cnt + 3'd1;
        end else begin
          b.res[b.cnt[1:0]] = '{ck, fqd_pkg::ChPct, 1'b0};
          b.cnt = b.cnt + 3'd1;
          b.res[b.cnt[1:0]] = '{ck, hd_q, 1'b0};
          b.cnt = b.cnt + 3'd1;
          do_plain = 1'b1;
        end
        esc_d = fqd_pkg::ESC_NONE;
        hd_d  = 8'h00;
      end
      default: begin
        esc_d    = fqd_pkg::ESC_NONE;
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (byte_i == fqd_pkg::ChAmp) begin
        b.res[b.cnt[1:0]] = '{fqd_pkg::KIND_MARK, 8'h00, ivp_d & vs_d};
        b.cnt = b.cnt + 3'd1;
        ended = 1'b1;
        ivp_d = 1'b0;
        vs_d  = 1'b0;
        esc_d = fqd_pkg::ESC_NONE;
        hd_d  = 8'h00;
      end else if (!ivp_d && byte_i == fqd_pkg::ChEq) begin
        ivp_d = 1'b1;
      end else begin
        if (ivp_d) vs_d = 1'b1;
        if (byte_i == fqd_pkg::ChPct) begin
          esc_d = fqd_pkg::ESC_PCT;
        end else begin
          b.res[b.cnt[1:0]] = '{ivp_d ? fqd_pkg::KIND_VALUE : fqd_pkg::KIND_NAME,
                                (byte_i == fqd_pkg::ChPlus) ? fqd_pkg::ChSpace : byte_i,
                                1'b0};
          b.cnt = b.cnt + 3'd1;
        end
      end
    end

    // end of query: flush pending escape, close the pair, clear state
    if (final_i) begin
      ck = ivp_d ? fqd_pkg::KIND_VALUE : fqd_pkg::KIND_NAME;
      if (esc_d == fqd_pkg::ESC_PCT || esc_d == fqd_pkg::ESC_DIGIT) begin
        b.res[b.cnt[1:0]] = '{ck, fqd_pkg::ChPct, 1'b0};
        b.cnt = b.cnt + 3'd1;
      end
      if (esc_d == fqd_pkg::ESC_DIGIT) begin
        b.res[b.cnt[1:0]] = '{ck, hd_d, 1'b0};
        b.cnt = b.cnt + 3'd1;
      end
      if (!ended) begin
        b.res[b.cnt[1:0]] = '{fqd_pkg::KIND_MARK, 8'h00, ivp_d & vs_d};
        b.cnt = b.cnt + 3'd1;
      end
      ivp_d = 1'b0;
      vs_d  = 1'b0;
      esc_d = fqd_pkg::ESC_NONE;
      hd_d  = 8'h00;
    end
    batch_o = b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivp_q <= 1'b0;
      vs_q  <= 1'b0;
      esc_q <= fqd_pkg::ESC_NONE;
      hd_q  <= 8'h00;
    end else if (acc_i) begin
      ivp_q <= ivp_d;
      vs_q  <= vs_d;
      esc_q <= esc_d;
      hd_q  <= hd_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fqd_obuf.sv =====
// Result register holding one transaction's results, drained one per cycle while m_ready_i is high.
`timescale 1ns / 1ps
`default_nettype none
module fqd_obuf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire fqd_pkg::batch_t batch_i,
  input  wire logic            m_ready_i,
  output logic                 s_ready_o,
  output logic                 m_valid_o,
  output fqd_pkg::res_t        res_o,
  output logic                 last_o
);

  fqd_pkg::res_t [fqd_pkg::MaxRes-1:0] res_q;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] rd_q, rd_d;
  logic       take;

  assign m_valid_o = (cnt_q != 3'd0);
  assign take      = m_valid_o & m_ready_i;
  assign s_ready_o = (cnt_q == 3'd0) || (cnt_q == 3'd1 && m_ready_i);
  assign res_o     = res_q[rd_q];
  assign last_o    = (cnt_q == 3'd1);

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load_i) begin
      cnt_d = batch_i.cnt;
      rd_d  = 2'd0;
    end else if (take) begin
      cnt_d = cnt_q - 3'd1;
      rd_d  = rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      rd_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= batch_i.res;
  end

endmodule
`default_nettype wire

// ===== sv/form_query_decoder.sv =====
// Top level of the form-urlencoded query decoder.
//
//  port group   dir  tdata                          tuser          tlast
//  s_axis_*     in   [7:0] raw byte                 -              last byte of query
//  m_axis_*     out  [7:0] byte, [8] pair keep      [1:0] kind     last result of a byte
//
// One input transaction per cycle while s_axis_tready_o is high: the decode is
// one combinational pass from the decode state and the incoming byte into a
// result register of up to four entries. Most bytes give zero or one result and
// stream at one per cycle while the output is ready; a byte that gives more
// results holds s_axis_tready_o low while the result register drains. The input
// stays ready while the last pending result is taken. Reset clears the decode
// state and empties the result register; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none
module form_query_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic        s_axis_tlast_i,   // in_final
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] out_byte, [8] pair_keep, rest zero
  output logic [1:0]       m_axis_tuser_o,   // [1:0] out_kind
  output logic             m_axis_tlast_o    // run_last
);

  logic            acc;
  fqd_pkg::batch_t batch;
  fqd_pkg::res_t   res;

  // input transaction accepted
  assign acc = s_axis_tvalid_i & s_axis_tready_o;

  fqd_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .byte_i  (s_axis_tdata_i),
    .final_i (s_axis_tlast_i),
    .batch_o (batch)
  );

  fqd_obuf u_obuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (acc),
    .batch_i   (batch),
    .m_ready_i (m_axis_tready_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .res_o     (res),
    .last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'd0, res.keep, res.dat};
  assign m_axis_tuser_o = res.kind;

endmodule
`default_nettype wire
